>>> hw/rtl/wnns_pkg.sv
// Package for the weighted nearest neighbour search block.
// Holds the opcode and configuration index codes, field widths, the unit weight and the front-to-back command type.
// No dependencies.
package wnns_pkg;
	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_COORD  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] CFG_WINDOW = 2'd0;
	localparam logic [1:0] CFG_POINTS = 2'd1;
	localparam logic [1:0] CFG_DIMS   = 2'd2;

	localparam int unsigned PIDX_W = 10;
	localparam int unsigned DIDX_W = 4;
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned ACC_W  = 64;

	localparam logic signed [VAL_W-1:0] WEIGHT_ONE = 16'sd256;

	typedef struct packed {
		logic [1:0]              op;
		logic [PIDX_W-1:0]       pidx;
		logic [DIDX_W-1:0]       didx;
		logic signed [VAL_W-1:0] value;
	} cmd_t;
endpackage

>>> hw/rtl/weighted_nearest_neighbour_search.sv
// Top level of the weighted nearest neighbour search block.
// Instantiates wnns_front and wnns_back and holds configuration; uses wnns_pkg.
//
// Channel  | Handshake          | Payload
// input    | push / full        | opcode, point_index, dim_index, value
// result   | pop / empty        | neighbour_index, none_found
// config   | cfg_we             | cfg_index, cfg_data
//
// A transaction waits in the front queue until the back part is idle; a weight or
// coordinate write is applied as the back part takes it. A query first loads the
// query point, then for each candidate point sets up, reads one value per dimension,
// drains the multiply-accumulate pipeline and compares; a point inside the window is
// skipped, and at the end the answer is parked; the single coordinate memory read
// port sets that pace. Reset clears configuration to its defaults and the weights to
// 1.0; the coordinate memory is not cleared. A parked answer waits in an output
// register while the back part goes on; a second finished answer stalls the back
// part, and then the two-entry front queue fills and raises full.
module weighted_nearest_neighbour_search #(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned MAX_DIMS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [9:0]  point_index,
	input  logic [3:0]  dim_index,
	input  logic signed [15:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [9:0]  neighbour_index,
	output logic        none_found,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	logic [9:0]  win_q;
	logic [10:0] npts_q;
	logic [4:0]  ndims_q;
	logic        cmd_valid, cmd_take, res_valid;
	wnns_pkg::cmd_t cmd;

	// Configuration registers; writes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0; npts_q <= 11'd1; ndims_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wnns_pkg::CFG_WINDOW: win_q   <= cfg_data[9:0];
				wnns_pkg::CFG_POINTS: npts_q  <= cfg_data;
				wnns_pkg::CFG_DIMS:   ndims_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	wnns_front u_front (
		.clk, .arst_n, .push, .full, .opcode, .point_index, .dim_index, .value,
		.cmd_valid, .cmd, .cmd_take
	);

	wnns_back #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take,
		.win(win_q), .npts(npts_q), .ndims(ndims_q),
		.res_valid, .res_take(pop), .res_index(neighbour_index), .res_none(none_found)
	);

	assign empty = !res_valid;
endmodule

>>> hw/rtl/wnns_front.sv
// Front part: accepts input transactions, drops unused opcodes and
// queues commands for the back part in a two-entry queue. Uses wnns_pkg.
module wnns_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [wnns_pkg::PIDX_W-1:0] point_index,
	input  logic [wnns_pkg::DIDX_W-1:0] dim_index,
	input  logic signed [wnns_pkg::VAL_W-1:0] value,
	output logic                cmd_valid,
	output wnns_pkg::cmd_t      cmd,
	input  logic                cmd_take
);
	wnns_pkg::cmd_t slot_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           acc, keep;

	assign full = (cnt_q == 2'd2);
	assign acc  = push && !full;
	assign keep = acc && (opcode == wnns_pkg::OP_WEIGHT || opcode == wnns_pkg::OP_COORD
		|| opcode == wnns_pkg::OP_QUERY);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			slot_q[wr_q] <= '{op: opcode, pidx: point_index, didx: dim_index, value: value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (keep) wr_q <= !wr_q;
			if (cmd_take && cmd_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, cmd_take && cmd_valid};
		end
	end
endmodule

>>> hw/rtl/wnns_back.sv
// Back part: weight and coordinate stores, the scanning sequencer, the
// multiply-accumulate datapath and the answer register. Uses wnns_pkg.
module wnns_back #(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned MAX_DIMS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  wnns_pkg::cmd_t      cmd,
	output logic                cmd_take,
	input  logic [9:0]          win,
	input  logic [10:0]         npts,
	input  logic [4:0]          ndims,
	output logic                res_valid,
	input  logic                res_take,
	output logic [wnns_pkg::PIDX_W-1:0] res_index,
	output logic                res_none
);
	localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int unsigned PCW = $clog2(MAX_POINTS + 1);
	localparam int unsigned DCW = $clog2(MAX_DIMS + 1);
	localparam int unsigned AW  = PW + DW;
	localparam int unsigned GW  = (PW > 11) ? PW : 11;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOADQ = 3'd1;
	localparam logic [2:0] ST_PT   = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] st_q;
	logic signed [15:0] mem [MAX_POINTS*MAX_DIMS];
	logic signed [15:0] wgt_q [MAX_DIMS];
	logic signed [15:0] qc_q [MAX_DIMS];
	logic signed [15:0] rd_s1;
	logic [AW-1:0] raddr;
	logic [wnns_pkg::PIDX_W-1:0] qp_q;
	logic [PW-1:0] j_q;
	logic          qok_q;
	logic [PCW-1:0] n_c;
	logic [DCW-1:0] m_c;
	logic [DCW-1:0] k_q;      // issue count
	logic [DCW-1:0] kr_q;     // index of data in rd_s1
	logic           rv_s1, mv_s2, pv_s3;
	logic signed [16:0] diff_s2;
	logic signed [15:0] w_s2;
	logic [33:0]    sq_s3;
	logic signed [15:0] w_s3;
	logic signed [50:0] pr_s4;
	logic           pv_s4;
	logic signed [wnns_pkg::ACC_W-1:0] acc_q, best_q;
	logic [PW-1:0]  best_idx_q;
	logic           found_q;
	logic [GW-1:0]  gap;
	logic           wpend;
	logic           res_v_q;
	logic [wnns_pkg::PIDX_W-1:0] res_idx_q;
	logic           res_none_q;

	assign n_c = (32'(npts) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(npts);
	assign m_c = (32'(ndims) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(ndims);
	assign cmd_take = cmd_valid && st_q == ST_IDLE;
	assign res_valid = res_v_q;
	assign res_index = res_idx_q;
	assign res_none = res_none_q;
	assign gap = (GW'(qp_q) > GW'(j_q)) ? GW'(qp_q) - GW'(j_q) : GW'(j_q) - GW'(qp_q);
	assign wpend = rv_s1 || mv_s2 || pv_s3 || pv_s4;

	always_comb begin
		raddr = {PW'(qp_q), DW'(k_q)};
		if (st_q == ST_MAC) raddr = {j_q, DW'(k_q)};
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.op == wnns_pkg::OP_COORD && 32'(cmd.pidx) < MAX_POINTS
			&& 32'(cmd.didx) < MAX_DIMS)
			mem[{PW'(cmd.pidx), DW'(cmd.didx)}] <= cmd.value;
		rd_s1 <= mem[raddr];
	end

	// datapath: diff, square, weight, accumulate
	always_ff @(posedge clk) begin
		diff_s2 <= 17'(qc_q[DW'(kr_q)]) - 17'(rd_s1);
		w_s2 <= wgt_q[DW'(kr_q)];
		sq_s3 <= unsigned'(34'(diff_s2) * 34'(diff_s2));
		w_s3 <= w_s2;
		pr_s4 <= $signed({1'b0, sq_s3}) * w_s3;
		if (st_q == ST_LOADQ && rv_s1) qc_q[DW'(kr_q)] <= qok_q ? rd_s1 : 16'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; found_q <= 1'b0; rv_s1 <= 1'b0; mv_s2 <= 1'b0;
			pv_s3 <= 1'b0; pv_s4 <= 1'b0; k_q <= '0; kr_q <= '0;
			res_v_q <= 1'b0; res_idx_q <= '0; res_none_q <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) wgt_q[i] <= wnns_pkg::WEIGHT_ONE;
		end else begin
			mv_s2 <= rv_s1 && st_q == ST_MAC;
			pv_s3 <= mv_s2;
			pv_s4 <= pv_s3;
			if (pv_s4) acc_q <= acc_q + 64'(pr_s4);
			rv_s1 <= (st_q == ST_LOADQ || st_q == ST_MAC) && k_q < m_c;
			if (rv_s1) kr_q <= kr_q + 1'b1;
			// The answer register frees the scan as soon as its answer is parked.
			res_v_q <= (st_q == ST_OUT && (!res_v_q || res_take)) || (res_v_q && !res_take);
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.op == wnns_pkg::OP_WEIGHT && 32'(cmd.didx) < MAX_DIMS)
							wgt_q[DW'(cmd.didx)] <= cmd.value;
						if (cmd.op == wnns_pkg::OP_QUERY) begin
							qp_q <= cmd.pidx;
							qok_q <= 32'(cmd.pidx) < MAX_POINTS;
							k_q <= '0; kr_q <= '0; found_q <= 1'b0;
							st_q <= ST_LOADQ;
						end
					end
				end
				ST_LOADQ: begin
					if (k_q < m_c) begin
						k_q <= k_q + 1'b1;
					end else if (!rv_s1) begin
						j_q <= '0; st_q <= ST_PT;
					end
				end
				ST_PT: begin
					if (PCW'(j_q) >= n_c || n_c == '0) st_q <= ST_OUT;
					else if (gap <= GW'(win)) begin
						if (PCW'(j_q) + 1'b1 >= n_c) st_q <= ST_OUT;
						else j_q <= j_q + 1'b1;
					end else begin
						k_q <= '0; kr_q <= '0; acc_q <= '0; st_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q < m_c) begin
						k_q <= k_q + 1'b1;
					end else if (!wpend) st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!found_q || acc_q <= best_q) begin
						best_q <= acc_q; best_idx_q <= j_q; found_q <= 1'b1;
					end
					if (PCW'(j_q) + 1'b1 >= n_c) st_q <= ST_OUT;
					else begin
						j_q <= j_q + 1'b1; st_q <= ST_PT;
					end
				end
				ST_OUT: begin
					if (!res_v_q || res_take) begin
						res_idx_q <= found_q ? wnns_pkg::PIDX_W'(best_idx_q) : '0;
						res_none_q <= !found_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> tb/tb_weighted_nearest_neighbour_search.sv
// Self-checking testbench for weighted_nearest_neighbour_search.
// Depends on wnns_pkg and the block's RTL; the checker predicts every query answer not typed in.
module tb_weighted_nearest_neighbour_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 1024;
	localparam int NDIM = 16;
	// Points and coordinates written before any query reads them.
	localparam int FILL_PTS = 8;
	localparam int FILL_DIMS = 4;
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Cycles without any transaction before the run is declared hung. The limit is set to
	// outlast a worst-case query over 1024 points and the receiver's one long hold-off.
	localparam int STALL_LIMIT = 60000;
	// Writes produce no answer, so queued writes may still be draining when the
	// last answer arrives; this many quiet cycles cover a full front queue.
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [9:0] idx;
		logic       none;
	} answer_t;

	typedef struct {
		logic [1:0]         op;
		logic [9:0]         pidx;
		logic [3:0]         didx;
		logic signed [15:0] val;
		bit                 typed;
		logic [9:0]         e_idx;
		logic               e_none;
	} stim_row_t;

	typedef struct {
		int  win;
		int  pts;
		int  dims;
		bit  wide;     // queries anywhere among 1024 points, no coordinates in use
		bit  narrow;   // coordinates from a tiny set, so equal distances occur
		int  items;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] opcode = wnns_pkg::OP_WEIGHT;
	logic [9:0] point_index = '0;
	logic [3:0] dim_index = '0;
	logic signed [15:0] value = '0;
	logic empty;
	logic pop = 1'b0;
	logic [9:0] neighbour_index;
	logic none_found;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = wnns_pkg::CFG_WINDOW;
	logic [10:0] cfg_data = '0;

	// Checker's own copy of the block's state.
	logic signed [15:0] coord_mem [0:NPTS-1][0:NDIM-1];
	logic signed [15:0] weight_mem [0:NDIM-1];
	int win_cfg, pts_cfg, dims_cfg;

	answer_t answers_due[$];
	int errors = 0;
	int pops_done = 0;
	int idle_run = 0;
	bit burst_mode = 1'b0;

	weighted_nearest_neighbour_search u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.opcode(opcode), .point_index(point_index), .dim_index(dim_index), .value(value),
		.empty(empty), .pop(pop),
		.neighbour_index(neighbour_index), .none_found(none_found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Nearest candidate outside the exclusion window; the later index wins ties.
	function automatic answer_t nearest_outside_window(input int q);
		answer_t a;
		int n, m;
		longint wdist, best_dist, diff;
		bit found;
		n = (pts_cfg > NPTS) ? NPTS : pts_cfg;
		m = (dims_cfg > NDIM) ? NDIM : dims_cfg;
		found = 1'b0;
		best_dist = 0;
		a.idx = '0;
		for (int j = 0; j < n; j++) begin
			if (((q > j) ? q - j : j - q) <= win_cfg)
				continue;
			wdist = 0;
			for (int k = 0; k < m; k++) begin
				diff = longint'(coord_mem[q][k]) - longint'(coord_mem[j][k]);
				wdist += diff * diff * longint'(weight_mem[k]);
			end
			if (!found || wdist <= best_dist) begin
				best_dist = wdist;
				a.idx = j[9:0];
				found = 1'b1;
			end
		end
		a.none = !found;
		return a;
	endfunction

	// Offers one transaction after a random gap, or none in burst mode, and updates the
	// prediction once the block takes it. A typed expectation replaces the predicted answer.
	task automatic send_cmd(input logic [1:0] op, input logic [9:0] p, input logic [3:0] d,
			input logic signed [15:0] v, input bit typed = 1'b0,
			input logic [9:0] e_idx = '0, input logic e_none = 1'b0);
		int gap;
		answer_t a;
		gap = burst_mode ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= op;
		point_index <= p;
		dim_index <= d;
		value <= v;
		push <= 1'b1;
		do @(posedge clk); while (full);
		case (op)
			wnns_pkg::OP_WEIGHT: weight_mem[d] = v;
			wnns_pkg::OP_COORD:  coord_mem[p][d] = v;
			wnns_pkg::OP_QUERY: begin
				a = nearest_outside_window(p);
				if (typed) begin
					a.idx = e_idx;
					a.none = e_none;
				end
				answers_due.push_back(a);
			end
			default: ;
		endcase
	endtask

	// Configuration only changes once every answer is back and queued writes have
	// had time to drain through the block.
	task automatic wait_quiet();
		push <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_cfg(input logic [1:0] idx, input int data);
		cfg_index <= idx;
		cfg_data <= data[10:0];
		cfg_we <= 1'b1;
		@(posedge clk);
		case (idx)
			wnns_pkg::CFG_WINDOW: win_cfg = data & 10'h3ff;
			wnns_pkg::CFG_POINTS: pts_cfg = data & 11'h7ff;
			wnns_pkg::CFG_DIMS:   dims_cfg = data & 5'h1f;
			default: ;
		endcase
	endtask

	function automatic logic signed [15:0] draw_value(input bit narrow);
		logic signed [15:0] pick [3] = '{16'sd0, 16'sd256, -16'sd256};
		if (narrow)
			return pick[$urandom_range(0, 2)];
		return 16'($urandom);
	endfunction

	// Directed rows. Answers are typed in where one candidate or none is plain:
	// the reset settings give one point in use and exclude only the query point itself.
	stim_row_t directed [] = '{
		'{wnns_pkg::OP_COORD,  10'd0,    4'd0,  16'sd32767,  0, 10'd0, 1'b0},
		'{wnns_pkg::OP_COORD,  10'd0,    4'd0,  16'sh8000,   0, 10'd0, 1'b0},
		'{wnns_pkg::OP_COORD,  10'd5,    4'd0,  16'sd32767,  0, 10'd0, 1'b0},
		'{wnns_pkg::OP_COORD,  10'd1023, 4'd0,  16'sd0,      0, 10'd0, 1'b0},
		'{wnns_pkg::OP_COORD,  10'd1023, 4'd15, -16'sd1,     0, 10'd0, 1'b0},
		// The query point itself is inside the window: nothing is found.
		'{wnns_pkg::OP_QUERY,  10'd0,    4'd0,  16'sd0,      1, 10'd0, 1'b1},
		// Queries beyond the points in use still compare against point 0.
		'{wnns_pkg::OP_QUERY,  10'd5,    4'd0,  16'sd0,      1, 10'd0, 1'b0},
		'{wnns_pkg::OP_QUERY,  10'd1023, 4'd15, -16'sd1,     1, 10'd0, 1'b0},
		'{wnns_pkg::OP_WEIGHT, 10'd0,    4'd0,  16'sh8000,   0, 10'd0, 1'b0},
		'{wnns_pkg::OP_WEIGHT, 10'd1023, 4'd15, 16'sd32767,  0, 10'd0, 1'b0},
		'{wnns_pkg::OP_QUERY,  10'd5,    4'd0,  16'sd0,      1, 10'd0, 1'b0},
		'{wnns_pkg::OP_WEIGHT, 10'd0,    4'd0,  16'sd0,      0, 10'd0, 1'b0},
		'{wnns_pkg::OP_QUERY,  10'd1023, 4'd0,  16'sd0,      1, 10'd0, 1'b0},
		// The unused opcode is dropped without an answer.
		'{OP_SPARE,            10'd1023, 4'd15, -16'sd1,     0, 10'd0, 1'b0},
		'{wnns_pkg::OP_WEIGHT, 10'd0,    4'd0,  16'sd256,    0, 10'd0, 1'b0},
		'{wnns_pkg::OP_QUERY,  10'd5,    4'd0,  16'sd0,      0, 10'd0, 1'b0}
	};

	// Settings walked after the directed rows, extremes included: a window that
	// excludes everything, zero and over-range counts, and all 1024 points in use
	// with no dimensions, so every distance ties.
	phase_t phases [] = '{
		'{0,    8,    4,  0, 0, 8},
		'{1023, 8,    31, 0, 0, 4},
		'{3,    8,    0,  0, 0, 4},
		'{2,    0,    4,  0, 0, 3},
		'{2,    7,    3,  0, 1, 8},
		'{1,    8,    4,  0, 0, 8},
		'{0,    1,    1,  0, 1, 3},
		'{1023, 2047, 0,  1, 0, 3},
		'{5,    1024, 0,  1, 1, 4},
		'{0,    1024, 0,  1, 0, 3}
	};

	// Result side: random pops, with one long hold-off so the block backs up.
	initial begin
		int gap;
		answer_t want;
		forever begin
			gap = (pops_done == 2) ? 2000 : (burst_mode ? 0 : $urandom_range(0, 13));
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty || !arst_n);
			pops_done++;
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected answer, index", neighbour_index, 0);
			end else begin
				want = answers_due.pop_front();
				if (neighbour_index !== want.idx)
					report_mismatch("neighbour_index", neighbour_index, want.idx);
				if (none_found !== want.none)
					report_mismatch("none_found", none_found, want.none);
			end
		end
	end

	// Watchdog: counts cycles in which no transaction of any kind happens.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Alternate between random gaps and back-to-back stretches on both sides.
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			burst_mode <= ~burst_mode;
	end

	initial begin
		int op_draw;
		logic [9:0] q;
		for (int k = 0; k < NDIM; k++)
			weight_mem[k] = wnns_pkg::WEIGHT_ONE;
		win_cfg = 0;
		pts_cfg = 1;
		dims_cfg = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_cmd(directed[i].op, directed[i].pidx, directed[i].didx, directed[i].val,
				directed[i].typed, directed[i].e_idx, directed[i].e_none);

		// Every coordinate that a query's answer can depend on is written first; phases
		// whose answers use coordinates stay within these points and dimensions.
		for (int p = 0; p < FILL_PTS; p++)
			for (int k = 0; k < FILL_DIMS; k++)
				send_cmd(wnns_pkg::OP_COORD, 10'(p), 4'(k), draw_value(p[0]));

		foreach (phases[i]) begin
			wait_quiet();
			write_cfg(wnns_pkg::CFG_WINDOW, phases[i].win);
			write_cfg(wnns_pkg::CFG_POINTS, phases[i].pts);
			write_cfg(wnns_pkg::CFG_DIMS, phases[i].dims);
			cfg_we <= 1'b0;
			for (int n = 0; n < phases[i].items; n++) begin
				op_draw = $urandom_range(0, 99);
				q = phases[i].wide ? 10'($urandom_range(0, NPTS - 1))
					: 10'($urandom_range(0, FILL_PTS - 1));
				if (op_draw < 45) begin
					send_cmd(wnns_pkg::OP_QUERY, q, 4'($urandom), 16'($urandom));
				end else if (op_draw < 65) begin
					send_cmd(wnns_pkg::OP_COORD, q, phases[i].wide ? 4'd0 : 4'($urandom),
						draw_value(phases[i].narrow));
				end else if (op_draw < 85) begin
					send_cmd(wnns_pkg::OP_WEIGHT, 10'($urandom), 4'($urandom),
						phases[i].narrow ? 16'sd256 : 16'($urandom));
				end else begin
					send_cmd(OP_SPARE, 10'($urandom), 4'($urandom), 16'($urandom));
					n--;
				end
			end
		end

		wait_quiet();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
